### rtl/tos_pkg.sv
// ============================================================================
// tos_pkg
// Shared types, codes and helpers of the timed output sequencer
// ============================================================================
package tos_pkg;

    localparam int C_TABLE_DEPTH = 128;
    localparam int C_INDEX_W     = 7;
    localparam int C_COUNT_W     = 8;
    localparam int C_TICK_W      = 16;
    localparam int C_LOOP_W      = 16;
    localparam int C_MEAS_W      = 20;
    localparam int C_TRIP_W      = 3;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_CFG_DATA_W  = 20;

    localparam logic [C_TICK_W-1:0] C_MIN_HOLD_TICKS = 16'd1;
    localparam logic [C_TICK_W-1:0] C_MAX_HOLD_TICKS = 16'd65535;

    typedef enum logic {
        ITEM_TICK  = 1'b0,
        ITEM_WRITE = 1'b1
    } t_item_mode;

    typedef enum logic [C_TRIP_W-1:0] {
        TRIP_NONE   = 3'd0,
        TRIP_LESS_V = 3'd1,
        TRIP_MORE_V = 3'd2,
        TRIP_LESS_C = 3'd3,
        TRIP_MORE_C = 3'd4,
        TRIP_LESS_P = 3'd5,
        TRIP_MORE_P = 3'd6
    } t_trip_mode;

    typedef enum logic [1:0] {
        STOP_NONE = 2'd0,
        STOP_DONE = 2'd1,
        STOP_TRIP = 2'd2
    } t_stop_event;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_START_POINT  = 3'd0,
        CFG_POINT_COUNT  = 3'd1,
        CFG_CYCLE_LIMIT  = 3'd2,
        CFG_TRIP_MODE    = 3'd3,
        CFG_TRIP_VOLTAGE = 3'd4,
        CFG_TRIP_CURRENT = 3'd5,
        CFG_TRIP_POWER   = 3'd6
    } t_cfg_index;

    typedef struct packed {
        t_item_mode             mode;
        logic                   run_enable;
        logic                   output_switch;
        logic [C_MEAS_W-1:0]    meas_voltage;
        logic [C_MEAS_W-1:0]    meas_current;
        logic [C_MEAS_W-1:0]    meas_power;
        logic [C_INDEX_W-1:0]   point_index;
        logic                   point_on;
        logic [C_TICK_W-1:0]    point_ticks;
    } t_item;

    typedef struct packed {
        logic                   drive_valid;
        logic                   drive_on;
        logic [C_INDEX_W-1:0]   current_index;
        logic [C_LOOP_W-1:0]    loop_count;
        logic [C_TICK_W-1:0]    remaining_ticks;
        logic                   running;
        t_stop_event            stop_event;
    } t_result;

    typedef struct packed {
        logic [C_INDEX_W-1:0]   start_point;
        logic [C_COUNT_W-1:0]   point_count;
        logic [C_LOOP_W-1:0]    cycle_limit;
        logic [C_TRIP_W-1:0]    trip_mode;
        logic [C_MEAS_W-1:0]    trip_voltage;
        logic [C_MEAS_W-1:0]    trip_current;
        logic [C_MEAS_W-1:0]    trip_power;
    } t_cfg;

    typedef struct packed {
        logic                   on;
        logic [C_TICK_W-1:0]    ticks;
    } t_entry;

    // play index must hold any start point as well as any table index
    function automatic int play_width(int depth);
        return (depth > (1 << C_INDEX_W)) ? $clog2(depth) : C_INDEX_W;
    endfunction

    function automatic int cmp_width(int pw);
        return (pw + 1 > C_COUNT_W + 1) ? pw + 1 : C_COUNT_W + 1;
    endfunction

    function automatic logic [C_TICK_W-1:0] clamp_ticks(logic [C_TICK_W-1:0] t);
        logic [C_TICK_W-1:0] c;
        c = (t > C_MAX_HOLD_TICKS) ? C_MAX_HOLD_TICKS : t;
        c = (c < C_MIN_HOLD_TICKS) ? C_MIN_HOLD_TICKS : c;
        return c;
    endfunction

    function automatic logic [C_TICK_W-1:0] sat_inc16(logic [C_TICK_W-1:0] v);
        return (v != {C_TICK_W{1'b1}}) ? v + C_TICK_W'(1) : v;
    endfunction

endpackage

### rtl/tos_stream_if.sv
// ============================================================================
// tos_stream_if
// Valid/ready channel carrying one request or result per handshake
// ============================================================================
interface tos_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/tos_point_mem.sv
// ============================================================================
// tos_point_mem
// Point table: one write port, two registered read ports
// ============================================================================
module tos_point_mem import tos_pkg::*; #(
    parameter  int TABLE_DEPTH = C_TABLE_DEPTH,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output t_entry            o_rdata_a,
    output t_entry            o_rdata_b
);

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### rtl/tos_exec.sv
// ============================================================================
// tos_exec
// Execute stage: sequencer state, tick and trip update, result register
// ============================================================================
module tos_exec import tos_pkg::*; #(
    parameter  int TABLE_DEPTH = C_TABLE_DEPTH,
    localparam int PLAY_W      = play_width(TABLE_DEPTH),
    localparam int CW          = cmp_width(PLAY_W)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_load,
    input  t_item             i_item,
    input  t_entry            i_cur,
    input  t_entry            i_nxt,
    output logic              o_in_ready,
    output logic [PLAY_W-1:0] o_next_play,
    tos_stream_if.source      o_rsp
);

    logic                r_x_valid;
    t_item               r_x_item;
    logic [PLAY_W-1:0]   r_play;
    logic [C_TICK_W-1:0] r_hold;
    logic [C_LOOP_W-1:0] r_loops;
    logic                r_deb;
    logic                r_halted;
    logic                r_out_valid;
    t_result             r_out;

    logic [PLAY_W-1:0]   n_play;
    logic [C_TICK_W-1:0] n_hold;
    logic [C_LOOP_W-1:0] n_loops;
    logic                n_deb;
    logic                n_halted;
    t_result             n_out;

    logic                x_adv;
    logic                x_fire;
    logic [CW-1:0]       np1;
    logic [CW-1:0]       lim;
    logic                wrap;
    logic [PLAY_W-1:0]   start_ext;
    t_entry              cur_ent;
    logic                flag;
    logic                clr;
    logic                done;
    logic                dv;
    logic                don;
    t_stop_event         ev;
    logic [C_TICK_W-1:0] fin_ticks;

    assign x_adv       = !r_out_valid || o_rsp.ready;
    assign x_fire      = r_x_valid && x_adv;
    assign o_in_ready  = !r_x_valid || x_adv;
    assign o_next_play = r_x_valid ? n_play : r_play;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign start_ext = PLAY_W'(i_cfg.start_point);
    assign np1       = CW'(r_play) + CW'(1);
    assign lim       = CW'(i_cfg.start_point) + CW'(i_cfg.point_count);
    assign wrap      = (np1 >= CW'(TABLE_DEPTH)) || (np1 >= lim);

    // forward a point write to its own result
    always_comb begin
        cur_ent = i_cur;
        if (r_x_item.mode == ITEM_WRITE
                && CW'(r_x_item.point_index) == CW'(r_play)
                && CW'(r_x_item.point_index) < CW'(TABLE_DEPTH)) begin
            cur_ent.on    = r_x_item.point_on;
            cur_ent.ticks = clamp_ticks(r_x_item.point_ticks);
        end
    end

    always_comb begin
        flag = 1'b0;
        clr  = 1'b1;
        unique case (t_trip_mode'(i_cfg.trip_mode))
            TRIP_NONE:   clr  = 1'b0;
            TRIP_LESS_V: flag = r_x_item.meas_voltage > i_cfg.trip_voltage;
            TRIP_MORE_V: flag = r_x_item.meas_voltage < i_cfg.trip_voltage;
            TRIP_LESS_C: flag = r_x_item.meas_current > i_cfg.trip_current;
            TRIP_MORE_C: flag = r_x_item.meas_current < i_cfg.trip_current;
            TRIP_LESS_P: flag = r_x_item.meas_power > i_cfg.trip_power;
            TRIP_MORE_P: flag = r_x_item.meas_power < i_cfg.trip_power;
            default:     flag = 1'b0;
        endcase
    end

    always_comb begin
        n_play    = r_play;
        n_hold    = r_hold;
        n_loops   = r_loops;
        n_deb     = r_deb;
        n_halted  = r_halted;
        dv        = 1'b0;
        don       = 1'b0;
        ev        = STOP_NONE;
        done      = 1'b0;
        fin_ticks = cur_ent.ticks;
        if (r_x_item.mode == ITEM_WRITE) begin
            fin_ticks = cur_ent.ticks;
        end else if (!r_x_item.run_enable) begin
            n_play   = start_ext;
            n_hold   = '0;
            n_loops  = '0;
            n_deb    = 1'b0;
            n_halted = 1'b0;
        end else if (!r_halted) begin
            if (r_loops == '0 && r_play == start_ext) begin
                dv  = 1'b1;
                don = cur_ent.on;
            end
            if (r_hold >= cur_ent.ticks) begin
                n_hold    = '0;
                fin_ticks = i_nxt.ticks;
                if (wrap) begin
                    n_play  = start_ext;
                    n_loops = sat_inc16(r_loops);
                    if (i_cfg.cycle_limit != '0 && n_loops >= i_cfg.cycle_limit) begin
                        n_halted = 1'b1;
                        ev       = STOP_DONE;
                        done     = 1'b1;
                    end
                end else begin
                    n_play = np1[PLAY_W-1:0];
                end
                if (!done) begin
                    dv  = 1'b1;
                    don = i_nxt.on;
                end
            end
            if (!done) begin
                n_hold = sat_inc16(n_hold);
                if (!r_x_item.output_switch) begin
                    if (!flag) begin
                        if (clr) begin
                            n_deb = 1'b0;
                        end
                    end else if (!r_deb) begin
                        n_deb = 1'b1;
                    end else begin
                        n_halted = 1'b1;
                        ev       = STOP_TRIP;
                    end
                end
            end
        end
    end

    always_comb begin
        n_out.drive_valid     = dv;
        n_out.drive_on        = dv & don;
        n_out.current_index   = n_play[C_INDEX_W-1:0];
        n_out.loop_count      = n_loops;
        n_out.remaining_ticks = (fin_ticks > n_hold) ? fin_ticks - n_hold : '0;
        n_out.running         = r_x_item.run_enable && !n_halted;
        n_out.stop_event      = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_play      <= '0;
            r_hold      <= '0;
            r_loops     <= '0;
            r_deb       <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_x_valid <= i_load;
            end
            if (x_fire) begin
                r_out_valid <= 1'b1;
                r_play      <= n_play;
                r_hold      <= n_hold;
                r_loops     <= n_loops;
                r_deb       <= n_deb;
                r_halted    <= n_halted;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x_item <= i_item;
        end
        if (x_fire) begin
            r_out <= n_out;
        end
    end

    a_run_off_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && r_x_item.mode == ITEM_TICK && !r_x_item.run_enable
        |=> r_play == PLAY_W'($past(i_cfg.start_point)) && r_hold == '0 && !r_halted)
        else $error("disabled tick did not rewind play");

    a_stop_sets_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && n_out.stop_event != STOP_NONE |=> r_halted)
        else $error("stop reported without halting");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && r_halted && r_x_item.mode == ITEM_TICK && r_x_item.run_enable
        |-> !n_out.drive_valid && n_out.stop_event == STOP_NONE && !n_out.running)
        else $error("halted sequencer drove output");

    a_loops_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && r_x_item.mode == ITEM_TICK && r_x_item.run_enable
        |=> r_loops >= $past(r_loops))
        else $error("loop count went backwards");

    a_write_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire && r_x_item.mode == ITEM_WRITE
        |=> $stable(r_play) && $stable(r_loops) && $stable(r_halted))
        else $error("point write disturbed play state");

endmodule

### rtl/timed_output_sequencer_with_trip.sv
// ============================================================================
// timed_output_sequencer_with_trip
// Plays a table of timed on/off points with loop count and trip stop
// ============================================================================
//  channel  | side   | handshake        | payload
//  i_req    | sink   | valid & ready    | t_item: tick or point write
//  o_rsp    | source | valid & ready    | t_result: one per request
//  i_cfg_*  | in     | i_cfg_we         | register index and data
//
//  one request per cycle while results are taken; its result is registered
//  (point table read at the accept edge, then execute stage)
//  next request's table addresses come from the execute stage's next index
//  synchronous reset clears play state; table holds garbage until written
//  a stalled result holds the execute stage and the table read data
// ============================================================================
module timed_output_sequencer_with_trip import tos_pkg::*; #(
    parameter int TABLE_DEPTH = C_TABLE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tos_stream_if.sink              i_req,
    tos_stream_if.source            o_rsp,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int PLAY_W = play_width(TABLE_DEPTH);
    localparam int CW     = cmp_width(PLAY_W);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    t_cfg              r_cfg;
    logic              r_a_ok;
    logic              r_b_ok;

    logic              in_ready;
    logic              accept;
    logic [PLAY_W-1:0] next_play;
    logic [PLAY_W-1:0] start_ext;
    logic [PLAY_W-1:0] addr_a;
    logic [PLAY_W-1:0] addr_b;
    logic [PLAY_W-1:0] pidx_ext;
    logic [CW-1:0]     np1;
    logic [CW-1:0]     lim;
    logic              we;
    t_entry            wdata;
    t_entry            rd_a;
    t_entry            rd_b;
    t_entry            cur;
    t_entry            nxt;

    assign i_req.ready = in_ready;
    assign accept      = i_req.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_point  <= '0;
            r_cfg.point_count  <= C_COUNT_W'(C_TABLE_DEPTH);
            r_cfg.cycle_limit  <= '0;
            r_cfg.trip_mode    <= '0;
            r_cfg.trip_voltage <= '0;
            r_cfg.trip_current <= '0;
            r_cfg.trip_power   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_idx))
                CFG_START_POINT:  r_cfg.start_point  <= i_cfg_wdata[C_INDEX_W-1:0];
                CFG_POINT_COUNT:  r_cfg.point_count  <= i_cfg_wdata[C_COUNT_W-1:0];
                CFG_CYCLE_LIMIT:  r_cfg.cycle_limit  <= i_cfg_wdata[C_LOOP_W-1:0];
                CFG_TRIP_MODE:    r_cfg.trip_mode    <= i_cfg_wdata[C_TRIP_W-1:0];
                CFG_TRIP_VOLTAGE: r_cfg.trip_voltage <= i_cfg_wdata[C_MEAS_W-1:0];
                CFG_TRIP_CURRENT: r_cfg.trip_current <= i_cfg_wdata[C_MEAS_W-1:0];
                CFG_TRIP_POWER:   r_cfg.trip_power   <= i_cfg_wdata[C_MEAS_W-1:0];
                default: ;
            endcase
        end
    end

    // port a: point in play for this request; port b: the point after it
    assign start_ext = PLAY_W'(r_cfg.start_point);
    assign addr_a    = (i_req.data.mode == ITEM_TICK && !i_req.data.run_enable)
                       ? start_ext : next_play;
    assign np1       = CW'(next_play) + CW'(1);
    assign lim       = CW'(r_cfg.start_point) + CW'(r_cfg.point_count);
    assign addr_b    = (np1 >= CW'(TABLE_DEPTH) || np1 >= lim)
                       ? start_ext : np1[PLAY_W-1:0];

    assign pidx_ext  = PLAY_W'(i_req.data.point_index);
    assign we        = accept && i_req.data.mode == ITEM_WRITE
                       && CW'(i_req.data.point_index) < CW'(TABLE_DEPTH);
    assign wdata.on    = i_req.data.point_on;
    assign wdata.ticks = clamp_ticks(i_req.data.point_ticks);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_ok <= CW'(addr_a) < CW'(TABLE_DEPTH);
            r_b_ok <= CW'(addr_b) < CW'(TABLE_DEPTH);
        end
    end

    assign cur = r_a_ok ? rd_a : '0;
    assign nxt = r_b_ok ? rd_b : '0;

    tos_point_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (pidx_ext[ADDR_W-1:0]),
        .i_wdata   (wdata),
        .i_re      (accept),
        .i_raddr_a (addr_a[ADDR_W-1:0]),
        .i_raddr_b (addr_b[ADDR_W-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    tos_exec #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load      (accept),
        .i_item      (i_req.data),
        .i_cur       (cur),
        .i_nxt       (nxt),
        .o_in_ready  (in_ready),
        .o_next_play (next_play),
        .o_rsp       (o_rsp)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the timed output sequencer with trip stop
// ============================================================================
//  a directed table (point writes, loop ends, completion, trip stop, debounce
//  clear) is followed by a full table load, randomly configured phases and a
//  soak with no idling that ends in sequence completion
//  every accepted request is run through a local copy of the sequencer and
//  every result is compared field by field; both channels idle at random and
//  the result side holds off once for a long stretch
// ============================================================================
module testbench;
    import tos_pkg::*;

    localparam logic [C_TRIP_W-1:0] TRIP_SPARE      = 3'd7;
    localparam logic [C_MEAS_W-1:0] MEAS_MAX        = '1;
    localparam logic [C_TICK_W-1:0] TICKS_MAX       = '1;
    localparam int                  IDLE_PCT        = 11;
    localparam int                  STALL_LIMIT     = 1000;
    localparam int                  HOLD_OFF_CYCLES = 90;
    localparam int                  N_PHASES        = 8;
    localparam int                  PHASE_REQUESTS  = 60;
    localparam int                  SOAK_TICKS      = 100;
    localparam int                  SOAK_POINT      = 5;

    typedef struct {
        bit                      is_reg;
        t_cfg_index              reg_idx;
        logic [C_CFG_DATA_W-1:0] reg_data;
        t_item                   item;
        bit                      typed;
        t_result                 want;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [C_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [C_CFG_DATA_W-1:0] i_cfg_wdata;

    tos_stream_if #(.t_payload(t_item))   req_if ();
    tos_stream_if #(.t_payload(t_result)) rsp_if ();

    timed_output_sequencer_with_trip DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // sequencer copy
    t_cfg                regs;
    t_entry              points [C_TABLE_DEPTH];
    logic [7:0]          play_pos;
    logic [C_TICK_W-1:0] held;
    logic [C_LOOP_W-1:0] loops;
    logic                trip_armed;
    logic                stopped;

    t_result pending_results[$];
    t_result want_res;
    t_result got_res;
    int      errors       = 0;
    int      quiet_cycles = 0;
    int      hold_left    = 0;
    bit      idle_on      = 1'b1;
    bit      hold_request = 1'b0;
    bit      held_off     = 1'b0;
    bit      req_offered  = 1'b0;

    function automatic t_result advance_sequencer(t_item it);
        t_result             r;
        logic [C_TICK_W-1:0] t;
        logic                done;
        logic                flag;
        logic                clears;
        r      = '0;
        done   = 1'b0;
        flag   = 1'b0;
        clears = 1'b1;
        if (it.mode == ITEM_WRITE) begin
            t = it.point_ticks;
            if (t > C_MAX_HOLD_TICKS) t = C_MAX_HOLD_TICKS;
            if (t < C_MIN_HOLD_TICKS) t = C_MIN_HOLD_TICKS;
            points[it.point_index].on    = it.point_on;
            points[it.point_index].ticks = t;
        end else if (!it.run_enable) begin
            play_pos   = {1'b0, regs.start_point};
            held       = '0;
            loops      = '0;
            trip_armed = 1'b0;
            stopped    = 1'b0;
        end else if (!stopped) begin
            if (loops == 0 && play_pos == {1'b0, regs.start_point}) begin
                r.drive_valid = 1'b1;
                r.drive_on    = points[play_pos[6:0]].on;
            end
            if (held >= points[play_pos[6:0]].ticks) begin
                held     = '0;
                play_pos = play_pos + 8'd1;
                if (play_pos >= C_TABLE_DEPTH ||
                    int'(play_pos) >= int'(regs.start_point) + int'(regs.point_count)) begin
                    play_pos = {1'b0, regs.start_point};
                    if (loops != TICKS_MAX) loops = loops + 1'b1;
                    if (regs.cycle_limit != 0 && loops >= regs.cycle_limit) begin
                        stopped      = 1'b1;
                        r.stop_event = STOP_DONE;
                        done         = 1'b1;
                    end
                end
                if (!done) begin
                    r.drive_valid = 1'b1;
                    r.drive_on    = points[play_pos[6:0]].on;
                end
            end
            if (!done) begin
                if (held != TICKS_MAX) held = held + 1'b1;
                if (!it.output_switch) begin
                    case (regs.trip_mode)
                        TRIP_NONE:   clears = 1'b0;
                        TRIP_LESS_V: flag = it.meas_voltage > regs.trip_voltage;
                        TRIP_MORE_V: flag = it.meas_voltage < regs.trip_voltage;
                        TRIP_LESS_C: flag = it.meas_current > regs.trip_current;
                        TRIP_MORE_C: flag = it.meas_current < regs.trip_current;
                        TRIP_LESS_P: flag = it.meas_power > regs.trip_power;
                        TRIP_MORE_P: flag = it.meas_power < regs.trip_power;
                        default:     flag = 1'b0;
                    endcase
                    if (!flag) begin
                        if (clears) trip_armed = 1'b0;
                    end else if (!trip_armed) begin
                        trip_armed = 1'b1;
                    end else begin
                        stopped      = 1'b1;
                        r.stop_event = STOP_TRIP;
                    end
                end
            end
        end
        t                 = points[play_pos[6:0]].ticks;
        r.current_index   = play_pos[6:0];
        r.loop_count      = loops;
        r.remaining_ticks = (t > held) ? t - held : '0;
        r.running         = it.run_enable && !stopped;
        return r;
    endfunction

    function automatic logic [C_MEAS_W-1:0] near(logic [C_MEAS_W-1:0] thr);
        case ($urandom_range(3))
            0: return C_MEAS_W'($urandom);
            1: return thr;
            2: return (thr == MEAS_MAX) ? thr : thr + 1'b1;
            default: return (thr == 0) ? thr : thr - 1'b1;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it.mode          = ITEM_TICK;
        it.run_enable    = 1'b1;
        it.output_switch = ($urandom_range(99) >= 60);
        it.meas_voltage  = near(regs.trip_voltage);
        it.meas_current  = near(regs.trip_current);
        it.meas_power    = near(regs.trip_power);
        it.point_index   = C_INDEX_W'($urandom);
        it.point_on      = 1'($urandom);
        it.point_ticks   = C_TICK_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.mode       = ITEM_WRITE;
            it.run_enable = 1'($urandom);
            pick = $urandom_range(99);
            if (pick < 75)      it.point_ticks = C_TICK_W'($urandom_range(1, 6));
            else if (pick < 88) it.point_ticks = '0;
            else if (pick < 92) it.point_ticks = TICKS_MAX;
        end else if (pick < 20) begin
            it.run_enable = 1'b0;
        end
        return it;
    endfunction

    function automatic t_cfg phase_config(int p);
        t_cfg c;
        c.start_point  = C_INDEX_W'($urandom_range(127));
        c.point_count  = ($urandom_range(3) == 0) ? C_COUNT_W'($urandom_range(128))
                                                  : C_COUNT_W'($urandom_range(1, 8));
        c.cycle_limit  = ($urandom_range(1) == 0) ? '0 : C_LOOP_W'($urandom_range(1, 5));
        c.trip_mode    = C_TRIP_W'($urandom_range(7));
        c.trip_voltage = C_MEAS_W'($urandom);
        c.trip_current = C_MEAS_W'($urandom);
        c.trip_power   = C_MEAS_W'($urandom);
        case (p)
            0: begin
                c.start_point = '0;
                c.point_count = 8'd128;
                c.cycle_limit = TICKS_MAX;
                c.trip_mode   = TRIP_NONE;
            end
            1: begin
                c.start_point  = 7'd127;
                c.point_count  = 8'd128;
                c.cycle_limit  = 16'd1;
                c.trip_mode    = TRIP_LESS_C;
                c.trip_voltage = MEAS_MAX;
                c.trip_current = MEAS_MAX;
                c.trip_power   = MEAS_MAX;
            end
            2: begin
                c.point_count  = '0;
                c.trip_mode    = TRIP_SPARE;
                c.trip_voltage = '0;
                c.trip_current = '0;
                c.trip_power   = '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic t_row blank_row();
        t_row r;
        r.is_reg   = 1'b0;
        r.reg_idx  = CFG_START_POINT;
        r.reg_data = '0;
        r.item     = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic t_row tick_row(bit en, bit sw, logic [C_MEAS_W-1:0] v,
                                      logic [C_MEAS_W-1:0] c, logic [C_MEAS_W-1:0] p);
        t_row r;
        r = blank_row();
        r.item.mode          = ITEM_TICK;
        r.item.run_enable    = en;
        r.item.output_switch = sw;
        r.item.meas_voltage  = v;
        r.item.meas_current  = c;
        r.item.meas_power    = p;
        return r;
    endfunction

    function automatic t_row write_row(bit en, logic [C_INDEX_W-1:0] idx, bit on,
                                       logic [C_TICK_W-1:0] ticks);
        t_row r;
        r = blank_row();
        r.item.mode        = ITEM_WRITE;
        r.item.run_enable  = en;
        r.item.point_index = idx;
        r.item.point_on    = on;
        r.item.point_ticks = ticks;
        return r;
    endfunction

    function automatic t_row reg_row(t_cfg_index idx, logic [C_CFG_DATA_W-1:0] v);
        t_row r;
        r = blank_row();
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = v;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, t_result w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    task automatic send_item(t_item it, bit typed = 1'b0, t_result want = '0);
        t_result predicted;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            if (req_offered) begin
                req_if.valid <= 1'b0;
                req_offered = 1'b0;
            end
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        req_offered = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = advance_sequencer(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        if (req_offered) begin
            req_if.valid <= 1'b0;
            req_offered = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_index idx, logic [C_CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_POINT:  regs.start_point  = v[C_INDEX_W-1:0];
            CFG_POINT_COUNT:  regs.point_count  = v[C_COUNT_W-1:0];
            CFG_CYCLE_LIMIT:  regs.cycle_limit  = v[C_LOOP_W-1:0];
            CFG_TRIP_MODE:    regs.trip_mode    = v[C_TRIP_W-1:0];
            CFG_TRIP_VOLTAGE: regs.trip_voltage = v;
            CFG_TRIP_CURRENT: regs.trip_current = v;
            CFG_TRIP_POWER:   regs.trip_power   = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_config(t_cfg c);
        wait_for_results();
        set_reg(CFG_START_POINT, C_CFG_DATA_W'(c.start_point));
        set_reg(CFG_POINT_COUNT, C_CFG_DATA_W'(c.point_count));
        set_reg(CFG_CYCLE_LIMIT, C_CFG_DATA_W'(c.cycle_limit));
        set_reg(CFG_TRIP_MODE, C_CFG_DATA_W'(c.trip_mode));
        set_reg(CFG_TRIP_VOLTAGE, c.trip_voltage);
        set_reg(CFG_TRIP_CURRENT, c.trip_current);
        set_reg(CFG_TRIP_POWER, c.trip_power);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %p",
                         $time, rsp_if.data);
            end else begin
                want_res = pending_results.pop_front();
                got_res  = rsp_if.data;
                check_field("drive_valid", want_res.drive_valid, got_res.drive_valid);
                check_field("drive_on", want_res.drive_on, got_res.drive_on);
                check_field("current_index", want_res.current_index, got_res.current_index);
                check_field("loop_count", want_res.loop_count, got_res.loop_count);
                check_field("remaining_ticks", want_res.remaining_ticks,
                            got_res.remaining_ticks);
                check_field("running", want_res.running, got_res.running);
                check_field("stop_event", want_res.stop_event, got_res.stop_event);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_request && !held_off) begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_row  plan[$];
        t_item it;
        t_cfg  c;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_START_POINT;
        i_cfg_wdata  <= '0;
        regs             = '0;
        regs.point_count = 8'd128;
        play_pos   = '0;
        held       = '0;
        loops      = '0;
        trip_armed = 1'b0;
        stopped    = 1'b0;

        // point writes with clamping, then the first steps of play
        plan.push_back(typed_row(write_row(0, 7'd0, 1, 16'd0),
                                 '{1'b0, 1'b0, 7'd0, 16'd0, 16'd1, 1'b0, STOP_NONE}));
        plan.push_back(typed_row(write_row(1, 7'd1, 0, TICKS_MAX),
                                 '{1'b0, 1'b0, 7'd0, 16'd0, 16'd1, 1'b1, STOP_NONE}));
        plan.push_back(write_row(0, 7'd127, 1, 16'd2));
        plan.push_back(write_row(1, 7'd2, 1, 16'd3));
        plan.push_back(typed_row(tick_row(0, 1, '0, '0, '0),
                                 '{1'b0, 1'b0, 7'd0, 16'd0, 16'd1, 1'b0, STOP_NONE}));
        plan.push_back(typed_row(tick_row(1, 1, MEAS_MAX, MEAS_MAX, MEAS_MAX),
                                 '{1'b1, 1'b1, 7'd0, 16'd0, 16'd0, 1'b1, STOP_NONE}));
        plan.push_back(typed_row(tick_row(1, 0, '0, '0, '0),
                                 '{1'b1, 1'b0, 7'd1, 16'd0, 16'd65534, 1'b1, STOP_NONE}));
        plan.push_back(tick_row(1, 1, 20'd5, 20'd5, 20'd5));
        // single point loops, then completion
        plan.push_back(reg_row(CFG_POINT_COUNT, 20'd1));
        plan.push_back(tick_row(0, 1, '0, '0, '0));
        repeat (3) plan.push_back(tick_row(1, 1, '0, '0, '0));
        plan.push_back(reg_row(CFG_CYCLE_LIMIT, 20'd2));
        plan.push_back(tick_row(0, 1, '0, '0, '0));
        repeat (4) plan.push_back(tick_row(1, 1, '0, '0, '0));
        // trip stop on two flagged ticks
        plan.push_back(reg_row(CFG_CYCLE_LIMIT, 20'd0));
        plan.push_back(reg_row(CFG_TRIP_MODE, 20'(TRIP_LESS_V)));
        plan.push_back(reg_row(CFG_TRIP_VOLTAGE, 20'd1000));
        plan.push_back(tick_row(0, 0, '0, '0, '0));
        plan.push_back(tick_row(1, 0, 20'd1001, '0, '0));
        plan.push_back(tick_row(1, 0, 20'd1001, '0, '0));
        plan.push_back(tick_row(1, 0, '0, '0, '0));
        // spare trip code never flags
        plan.push_back(reg_row(CFG_TRIP_MODE, 20'(TRIP_SPARE)));
        plan.push_back(tick_row(0, 0, '0, '0, '0));
        plan.push_back(tick_row(1, 0, MEAS_MAX, MEAS_MAX, MEAS_MAX));
        // last table point, debounce cleared by a clean tick
        plan.push_back(reg_row(CFG_START_POINT, 20'd127));
        plan.push_back(reg_row(CFG_POINT_COUNT, 20'd128));
        plan.push_back(reg_row(CFG_TRIP_MODE, 20'(TRIP_MORE_P)));
        plan.push_back(reg_row(CFG_TRIP_POWER, MEAS_MAX));
        plan.push_back(tick_row(0, 0, '0, '0, '0));
        plan.push_back(tick_row(1, 0, '0, '0, '0));
        plan.push_back(tick_row(1, 1, '0, '0, '0));
        plan.push_back(tick_row(1, 0, '0, '0, MEAS_MAX));
        plan.push_back(tick_row(1, 0, '0, '0, '0));
        plan.push_back(tick_row(1, 0, '0, '0, MEAS_MAX));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                wait_for_results();
                set_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // load every table point before random play
        for (int idx = 0; idx < C_TABLE_DEPTH; idx++) begin
            it = random_item();
            it.mode        = ITEM_WRITE;
            it.point_index = C_INDEX_W'(idx);
            it.point_ticks = C_TICK_W'($urandom_range(1, 4));
            send_item(it);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            load_config(phase_config(p));
            it = random_item();
            it.mode       = ITEM_TICK;
            it.run_enable = 1'b0;
            send_item(it);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (p == 2 && n == 20) hold_request = 1'b1;
                send_item(random_item());
            end
        end

        // soak without idling: a loop on every tick after the first, on a single short point
        idle_on = 1'b0;
        c = '0;
        c.start_point = C_INDEX_W'(SOAK_POINT);
        c.point_count = 8'd1;
        load_config(c);
        it = random_item();
        it.mode        = ITEM_WRITE;
        it.point_index = C_INDEX_W'(SOAK_POINT);
        it.point_ticks = 16'd1;
        send_item(it);
        it.mode       = ITEM_TICK;
        it.run_enable = 1'b0;
        send_item(it);
        repeat (SOAK_TICKS) begin
            it = random_item();
            it.mode       = ITEM_TICK;
            it.run_enable = 1'b1;
            send_item(it);
        end
        // a limit one above the loops done completes at the next loop end
        wait_for_results();
        set_reg(CFG_CYCLE_LIMIT, 20'(SOAK_TICKS));
        repeat (3) begin
            it = random_item();
            it.mode       = ITEM_TICK;
            it.run_enable = 1'b1;
            send_item(it);
        end
        idle_on = 1'b1;

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### timed_output_sequencer_with_trip.f
rtl/tos_pkg.sv
rtl/tos_stream_if.sv
rtl/tos_point_mem.sv
rtl/tos_exec.sv
rtl/timed_output_sequencer_with_trip.sv
tb/testbench.sv
